[rtl/miir_pkg.sv]
// Shared types, constants and helpers for the multichannel IIR filter.
// No dependencies; every other file in rtl/ depends on this package.
package miir_pkg;

    localparam int CHANNELS_DEF       = 4;
    localparam int ORDER_DEF          = 4;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 28;

    localparam int COEF_W     = 32;
    localparam int NUM_B      = 5;   // b0..b4
    localparam int NUM_A      = 4;   // a1..a4
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ORDER_W    = 3;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARM_POLICY  = 3'd0,
        REG_ACTIVE_ORDER = 3'd1,
        REG_B_PAIR_01    = 3'd2,
        REG_B_PAIR_23    = 3'd3,
        REG_B_4          = 3'd4,
        REG_A_PAIR_12    = 3'd5,
        REG_A_PAIR_34    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_B-1:0][COEF_W-1:0] b;   // b[k] = b_k
        logic [NUM_A-1:0][COEF_W-1:0] a;   // a[j] = a_(j+1)
    } coef_set_t;

    typedef struct packed {
        logic               load;    // input transfer into stage 1
        logic               adv;     // stage 1 moves to the result register
        logic               warm;    // stage 1 item is a warm-up item
        logic               policy;  // warm-up output: 0 zeros, 1 pass-through
        logic [ORDER_W-1:0] order;   // effective order
    } lane_ctrl_t;

    // Clamp the programmed order into 1..max_order.
    function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] v,
                                                     input int unsigned max_order);
        logic [ORDER_W-1:0] r;
        r = v;
        if (r == '0)
            r = 3'd1;
        if (32'(r) > max_order)
            r = ORDER_W'(max_order);
        return r;
    endfunction

endpackage

[rtl/miir_if.sv]
// Valid/ready channel interfaces for sample vectors and result vectors.
// Depends on miir_pkg for default widths.
interface miir_sample_if #(
    parameter int CHANNELS     = miir_pkg::CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = miir_pkg::SAMPLE_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface miir_result_if #(
    parameter int CHANNELS     = miir_pkg::CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = miir_pkg::SAMPLE_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] result;
    logic                                 warming;

    modport source (output valid, output result, output warming, input ready);
    modport sink   (input valid, input result, input warming, output ready);
endinterface

[rtl/miir_cfg.sv]
// Configuration registers and warm-up counter of the IIR filter.
// Depends on miir_pkg.
module miir_cfg #(
    parameter int ORDER = miir_pkg::ORDER_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [miir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [miir_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               accept,
    output logic                               policy,
    output logic [miir_pkg::ORDER_W-1:0]       order,
    output miir_pkg::coef_set_t                coefs,
    output logic                               warm_now
);
    import miir_pkg::*;

    logic               policy_reg, policy_next;
    logic [ORDER_W-1:0] order_reg, order_next;
    coef_set_t          coefs_reg, coefs_next;
    logic [ORDER_W-1:0] warm_left_reg, warm_left_next;

    always_comb
    begin
        policy_next    = policy_reg;
        order_next     = order_reg;
        coefs_next     = coefs_reg;
        warm_left_next = warm_left_reg;
        if (accept && warm_left_reg != '0)
            warm_left_next = warm_left_reg - 3'd1;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WARM_POLICY:  policy_next = cfg_wdata[0];
                REG_ACTIVE_ORDER:
                begin
                    order_next     = cfg_wdata[ORDER_W-1:0];
                    warm_left_next = eff_order(cfg_wdata[ORDER_W-1:0], ORDER);
                end
                REG_B_PAIR_01:
                begin
                    coefs_next.b[0] = cfg_wdata[31:0];
                    coefs_next.b[1] = cfg_wdata[63:32];
                end
                REG_B_PAIR_23:
                begin
                    coefs_next.b[2] = cfg_wdata[31:0];
                    coefs_next.b[3] = cfg_wdata[63:32];
                end
                REG_B_4:          coefs_next.b[4] = cfg_wdata[31:0];
                REG_A_PAIR_12:
                begin
                    coefs_next.a[0] = cfg_wdata[31:0];
                    coefs_next.a[1] = cfg_wdata[63:32];
                end
                REG_A_PAIR_34:
                begin
                    coefs_next.a[2] = cfg_wdata[31:0];
                    coefs_next.a[3] = cfg_wdata[63:32];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= 1'b0;
            order_reg     <= ORDER_RESET;
            coefs_reg     <= '0;
            warm_left_reg <= eff_order(ORDER_RESET, ORDER);
        end
        else
        begin
            policy_reg    <= policy_next;
            order_reg     <= order_next;
            coefs_reg     <= coefs_next;
            warm_left_reg <= warm_left_next;
        end
    end

    assign policy   = policy_reg;
    assign order    = eff_order(order_reg, ORDER);
    assign coefs    = coefs_reg;
    assign warm_now = (warm_left_reg != '0);

endmodule

[rtl/miir_lane.sv]
// One channel of the IIR filter: feedforward MAC stage, then feedback MAC,
// rounding and saturation into the result register. Depends on miir_pkg.
module miir_lane #(
    parameter int ORDER          = miir_pkg::ORDER_DEF,
    parameter int SAMPLE_WIDTH   = miir_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = miir_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  miir_pkg::lane_ctrl_t           ctrl,
    input  miir_pkg::coef_set_t            coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    output logic signed [SAMPLE_WIDTH-1:0] y
);
    import miir_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int PROD_W = SW + COEF_W;
    localparam int ACC_W  = PROD_W + 5;
    localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] S_MAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;

    logic signed [SW-1:0]     xh_reg [ORDER];   // x[n-1]..x[n-ORDER]
    logic signed [SW-1:0]     yh_reg [ORDER];   // y[n-1]..y[n-ORDER]
    logic signed [SW-1:0]     x_tap  [ORDER+1]; // x[n]..x[n-ORDER]
    logic signed [COEF_W-1:0] b_tap  [ORDER+1];
    logic signed [COEF_W-1:0] a_tap  [ORDER];

    logic signed [ACC_W-1:0]  ff_sum;
    logic signed [ACC_W-1:0]  ff_sum_reg;
    logic signed [SW-1:0]     x_s1_reg;
    logic signed [SW-1:0]     y_reg;
    logic signed [SW-1:0]     y_filt;
    logic signed [SW-1:0]     y_hist_in;
    logic signed [SW-1:0]     y_next;

    // Taps above the effective order, or above the stored coefficients, are zero.
    assign x_tap[0] = x_in;
    for (genvar k = 0; k <= ORDER; k++)
    begin : g_b_tap
        if (k > 0)
        begin : g_x
            assign x_tap[k] = xh_reg[k-1];
        end
        if (k < NUM_B)
        begin : g_on
            assign b_tap[k] = (3'(k) <= ctrl.order) ? coefs.b[k] : '0;
        end
        else
        begin : g_off
            assign b_tap[k] = '0;
        end
    end

    for (genvar j = 0; j < ORDER; j++)
    begin : g_a_tap
        if (j < NUM_A)
        begin : g_on
            assign a_tap[j] = (3'(j + 1) <= ctrl.order) ? coefs.a[j] : '0;
        end
        else
        begin : g_off
            assign a_tap[j] = '0;
        end
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] prod;
        ff_sum = '0;
        for (int k = 0; k <= ORDER; k++)
        begin
            prod   = x_tap[k] * b_tap[k];
            ff_sum = ff_sum + ACC_W'(prod);
        end
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] prod;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  shifted;
        acc = ff_sum_reg + RND;
        for (int j = 0; j < ORDER; j++)
        begin
            prod = yh_reg[j] * a_tap[j];
            acc  = acc - ACC_W'(prod);
        end
        shifted = acc >>> COEF_FRAC_BITS;
        if (shifted > S_MAX)
            y_filt = S_MAX[SW-1:0];
        else if (shifted < S_MIN)
            y_filt = S_MIN[SW-1:0];
        else
            y_filt = shifted[SW-1:0];
    end

    // Warm-up items feed the raw input into the output history.
    assign y_hist_in = ctrl.warm ? x_s1_reg : y_filt;
    assign y_next    = ctrl.warm ? (ctrl.policy ? x_s1_reg : '0) : y_filt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ORDER; j++)
            begin
                xh_reg[j] <= '0;
                yh_reg[j] <= '0;
            end
        end
        else
        begin
            if (ctrl.load)
            begin
                for (int j = 0; j < ORDER; j++)
                    xh_reg[j] <= x_tap[j];
            end
            if (ctrl.adv)
            begin
                yh_reg[0] <= y_hist_in;
                for (int j = 1; j < ORDER; j++)
                    yh_reg[j] <= yh_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ff_sum_reg <= ff_sum;
            x_s1_reg   <= x_in;
        end
        if (ctrl.adv)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

[rtl/multichannel_iir_filter_core.sv]
// Multichannel direct-form-I IIR filter, one lane per channel.
// Input transfers pass through the feedforward stage, then the feedback
// stage into the result register. Throughput: one item per cycle while the
// result sink is ready, set by the feedback multiply-accumulate of each lane.
// Reset clears both histories and loads the warm-up count with the order.
// Depends on miir_pkg, miir_if, miir_cfg and miir_lane.
module multichannel_iir_filter_core #(
    parameter int CHANNELS       = miir_pkg::CHANNELS_DEF,
    parameter int ORDER          = miir_pkg::ORDER_DEF,
    parameter int SAMPLE_WIDTH   = miir_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = miir_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    miir_sample_if.sink                     samples,
    miir_result_if.source                   results,
    input  logic                            cfg_we,
    input  logic [miir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [miir_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import miir_pkg::*;

    logic               policy;
    logic [ORDER_W-1:0] order;
    coef_set_t          coefs;
    logic               warm_now;

    logic accept;
    logic adv_out;
    logic move;

    logic s1_v_reg, s1_v_next;
    logic s1_warm_reg, s1_warm_next;
    logic out_v_reg, out_v_next;
    logic out_warm_reg, out_warm_next;

    lane_ctrl_t                            lane_ctrl;
    logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] lane_y;

    assign adv_out       = !out_v_reg || results.ready;
    assign move          = s1_v_reg && adv_out;
    assign samples.ready = !s1_v_reg || adv_out;
    assign accept        = samples.valid && samples.ready;

    miir_cfg #(
        .ORDER (ORDER)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .policy    (policy),
        .order     (order),
        .coefs     (coefs),
        .warm_now  (warm_now)
    );

    always_comb
    begin
        lane_ctrl.load   = accept;
        lane_ctrl.adv    = move;
        lane_ctrl.warm   = s1_warm_reg;
        lane_ctrl.policy = policy;
        lane_ctrl.order  = order;
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        miir_lane #(
            .ORDER          (ORDER),
            .SAMPLE_WIDTH   (SAMPLE_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .coefs (coefs),
            .x_in  (samples.sample[c]),
            .y     (lane_y[c])
        );
    end

    always_comb
    begin
        s1_v_next     = s1_v_reg;
        s1_warm_next  = s1_warm_reg;
        out_v_next    = out_v_reg;
        out_warm_next = out_warm_reg;
        if (move)
            s1_v_next = 1'b0;
        if (accept)
        begin
            s1_v_next    = 1'b1;
            s1_warm_next = warm_now;
        end
        if (results.ready)
            out_v_next = 1'b0;
        if (move)
        begin
            out_v_next    = 1'b1;
            out_warm_next = s1_warm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s1_warm_reg  <= 1'b0;
            out_v_reg    <= 1'b0;
            out_warm_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg     <= s1_v_next;
            s1_warm_reg  <= s1_warm_next;
            out_v_reg    <= out_v_next;
            out_warm_reg <= out_warm_next;
        end
    end

    // Merge lane results into one result transfer.
    assign results.valid   = out_v_reg;
    assign results.result  = lane_y;
    assign results.warming = out_warm_reg;

    a_warm_tag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && warm_now |=> s1_warm_reg)
        else $error("warm-up item not tagged in stage 1");

    a_warm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.warming && !policy |-> results.result == '0)
        else $error("warm-up result not zero with zero policy");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && out_v_reg && !results.ready |-> !accept)
        else $error("input transfer while pipeline is full");

endmodule
